// ----- design/pdds_pkg.sv -----
// Shared types and constants for the differential-drive PID step.
// Opcodes, sequencer state codes, register map, reset values and fixed constants.
// No dependencies.
`default_nettype none

package pdds_pkg;

	// input opcode, carried on s_tuser
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_RESET  = 1'b1;

	// configuration register map (index = paddr[4:2])
	localparam int unsigned PADDR_W = 5;
	localparam logic [2:0] REG_GAIN_P     = 3'd0;
	localparam logic [2:0] REG_GAIN_I     = 3'd1;
	localparam logic [2:0] REG_GAIN_D     = 3'd2;
	localparam logic [2:0] REG_BASE_SPEED = 3'd3;
	localparam logic [2:0] REG_MAX_SPEED  = 3'd4;

	localparam logic [7:0]  GAIN_P_RST     = 8'd50;
	localparam logic [7:0]  GAIN_I_RST     = 8'd60;
	localparam logic [7:0]  GAIN_D_RST     = 8'd12;
	localparam logic [16:0] BASE_SPEED_RST = 17'd44698;
	localparam logic [16:0] MAX_SPEED_RST  = 17'd74496;

	// microseconds per second
	localparam logic [19:0] US_PER_S = 20'd1000000;

	// bit-serial step counts
	localparam logic [5:0] STEPS_E_DT   = 6'd32; // |e| * dt, dt bits
	localparam logic [5:0] STEPS_GAIN   = 6'd8;  // gain bits
	localparam logic [5:0] STEPS_US     = 6'd20; // bits of US_PER_S
	localparam logic [5:0] STEPS_DIV_I  = 6'd56; // integral term quotient
	localparam logic [5:0] STEPS_DIV_D  = 6'd36; // derivative quotient

	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_MUL_E  = 13'b0000000000010,
		ST_INTEG  = 13'b0000000000100,
		ST_LOAD_I = 13'b0000000001000,
		ST_MUL_I  = 13'b0000000010000,
		ST_DIV_I  = 13'b0000000100000,
		ST_LOAD_N = 13'b0000001000000,
		ST_MUL_N  = 13'b0000010000000,
		ST_DIV_D  = 13'b0000100000000,
		ST_LOAD_D = 13'b0001000000000,
		ST_MUL_D  = 13'b0010000000000,
		ST_SUM    = 13'b0100000000000,
		ST_OUT    = 13'b1000000000000
	} state_t;

endpackage

`default_nettype wire

// ----- design/pid_differential_drive_step.sv -----
// PID line-follow step for a differential-drive robot, top level.
// Depends on pdds_pkg (state codes, register map, constants).
//
// Usage:
//   Sample words enter on the s_ stream; one result word leaves on the m_
//   stream for every accepted word. s_tuser = 1 resets the controller state
//   (integral, last error) and takes the word's timestamp as the new time base.
//   Gains and speeds are written through the APB port; the user must do so only
//   while the block is idle, as the block itself does not enforce it.
// Sequence:
//   A control sample runs through the shared one-bit-per-cycle shift-add
//   multiplier (32 + 8 + 20 + 8 steps) and the one-bit-per-cycle restoring
//   divider (56 + 36 steps) before its result is registered on m_; when the
//   elapsed time is zero the derivative path is skipped. A reset word goes
//   straight to the output register. One word is in work at a time; s_tready
//   is high whenever the sequencer is idle, and low while a word is in work.
// Reset:
//   arst_n clears the controller state, loads the register defaults and
//   empties the output register.
// Stalls:
//   A result waits in the output register while m_tready is low; the next
//   word is still accepted and computed, and it waits in its final step
//   until the output register frees up.
`default_nettype none

module pid_differential_drive_step (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// sample stream
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [47:0]                  s_tdata,  // line_error[15:0], time_us[47:16]
	input  wire logic                         s_tuser,  // opcode
	// result stream
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [71:0]                       m_tdata,  // left_speed[16:0], right_speed[33:17],
	                                                    // control_value[65:34], zeros[71:66]
	output logic                              m_tuser,  // zero_interval
	// configuration
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [pdds_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	function automatic logic [16:0] clamp_speed(input logic [33:0] v, input logic [16:0] maxv);
		logic [16:0] r;
		if (v[33]) begin
			r = 17'd0;
		end else if (v[32:0] > {16'd0, maxv}) begin
			r = maxv;
		end else begin
			r = v[16:0];
		end
		return r;
	endfunction

	pdds_pkg::state_t state_q;

	// configuration
	logic [7:0]  gain_p_q, gain_i_q, gain_d_q;
	logic [16:0] base_speed_q, max_speed_q;

	// controller state
	logic [31:0] last_time_q;
	logic [47:0] integral_q;
	logic [15:0] last_error_q;

	// word in work
	logic [15:0] e_q;
	logic [31:0] dt_q;
	logic [16:0] diff_q;
	logic        zero_q;
	logic [36:0] iterm_q;
	logic [37:0] ipterm_q;
	logic [31:0] u_q;

	// serial multiplier and divider
	logic [55:0] mul_acc_q;
	logic [47:0] mul_mcand_q;
	logic [31:0] mul_mplier_q;
	logic [55:0] div_num_q;
	logic [31:0] div_rem_q;
	logic [31:0] div_den_q;
	logic [5:0]  cnt_q;

	// output register
	logic        m_valid_q;
	logic [16:0] left_q, right_q;
	logic [31:0] cv_q;
	logic        zi_q;

	logic        accept, cfg_wr, step_last, out_load;
	logic        in_op;
	logic [15:0] in_err, eabs_in;
	logic [31:0] in_time, dt_in;
	logic [16:0] diff_in, diff_abs;
	logic [55:0] mul_acc_d;
	logic [32:0] div_part, div_sub;
	logic        div_ge;
	logic [31:0] div_rem_d;
	logic [55:0] div_num_d;
	logic [49:0] integ_ext, prod_ext, integ_sum;
	logic [47:0] integ_sat, integ_abs;
	logic [36:0] q_i, iterm;
	logic signed [24:0] pterm;
	logic [37:0] ipterm;
	logic [46:0] ip_ext, dmag, u_full;
	logic [31:0] u_sat;
	logic [33:0] spd_base, spd_u;

	assign in_op   = s_tuser;
	assign in_err  = s_tdata[15:0];
	assign in_time = s_tdata[47:16];

	assign s_tready  = (state_q == pdds_pkg::ST_IDLE);
	assign accept    = s_tvalid & s_tready;
	assign cfg_wr    = psel & penable & pwrite;
	assign pready    = 1'b1;
	assign step_last = (cnt_q == 6'd1);
	assign out_load  = (state_q == pdds_pkg::ST_OUT) && (!m_valid_q || m_tready);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, cv_q, right_q, left_q};
	assign m_tuser  = zi_q;

	always_comb begin
		prdata = 32'd0;
		case (paddr[4:2])
			pdds_pkg::REG_GAIN_P:     prdata = {24'd0, gain_p_q};
			pdds_pkg::REG_GAIN_I:     prdata = {24'd0, gain_i_q};
			pdds_pkg::REG_GAIN_D:     prdata = {24'd0, gain_d_q};
			pdds_pkg::REG_BASE_SPEED: prdata = {15'd0, base_speed_q};
			pdds_pkg::REG_MAX_SPEED:  prdata = {15'd0, max_speed_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// input side
	assign dt_in   = in_time - last_time_q;
	assign eabs_in = in_err[15] ? (~in_err + 16'd1) : in_err;
	assign diff_in = {in_err[15], in_err} - {last_error_q[15], last_error_q};

	// shift-add multiplier, multiplier bits MSB first
	assign mul_acc_d = {mul_acc_q[54:0], 1'b0}
		+ (mul_mplier_q[31] ? {8'd0, mul_mcand_q} : 56'd0);

	// restoring divider, quotient bits shift in behind the numerator
	assign div_part  = {div_rem_q, div_num_q[55]};
	assign div_sub   = div_part - {1'b0, div_den_q};
	assign div_ge    = (div_part >= {1'b0, div_den_q});
	assign div_rem_d = div_ge ? div_sub[31:0] : div_part[31:0];
	assign div_num_d = {div_num_q[54:0], div_ge};

	// integral update: add or subtract |e|*dt, saturate to 48 bits
	assign integ_ext = {{2{integral_q[47]}}, integral_q};
	assign prod_ext  = {2'd0, mul_acc_q[47:0]};
	assign integ_sum = e_q[15] ? (integ_ext - prod_ext) : (integ_ext + prod_ext);

	always_comb begin
		if (&integ_sum[49:47] || ~|integ_sum[49:47]) begin
			integ_sat = integ_sum[47:0];
		end else if (integ_sum[49]) begin
			integ_sat = {1'b1, 47'd0};
		end else begin
			integ_sat = {1'b0, {47{1'b1}}};
		end
	end

	assign integ_abs = integral_q[47] ? (~integral_q + 48'd1) : integral_q;

	// integral term sign follows the integral (gain is unsigned)
	assign q_i      = {1'b0, div_num_q[35:0]};
	assign iterm    = integral_q[47] ? (~q_i + 37'd1) : q_i;
	assign diff_abs = diff_q[16] ? (~diff_q + 17'd1) : diff_q;

	assign pterm  = $signed({1'b0, gain_p_q}) * $signed(e_q);
	assign ipterm = {iterm_q[36], iterm_q} + {{13{pterm[24]}}, pterm};

	// derivative term magnitude sits in the multiplier, sign is the error change
	assign ip_ext = {{9{ipterm_q[37]}}, ipterm_q};
	assign dmag   = zero_q ? 47'd0 : {2'd0, mul_acc_q[44:0]};
	assign u_full = diff_q[16] ? (ip_ext - dmag) : (ip_ext + dmag);

	always_comb begin
		if (&u_full[46:31] || ~|u_full[46:31]) begin
			u_sat = u_full[31:0];
		end else if (u_full[46]) begin
			u_sat = 32'h8000_0000;
		end else begin
			u_sat = 32'h7fff_ffff;
		end
	end

	assign spd_base = {17'd0, base_speed_q};
	assign spd_u    = {{2{u_q[31]}}, u_q};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q     <= pdds_pkg::GAIN_P_RST;
			gain_i_q     <= pdds_pkg::GAIN_I_RST;
			gain_d_q     <= pdds_pkg::GAIN_D_RST;
			base_speed_q <= pdds_pkg::BASE_SPEED_RST;
			max_speed_q  <= pdds_pkg::MAX_SPEED_RST;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				pdds_pkg::REG_GAIN_P:     gain_p_q     <= pwdata[7:0];
				pdds_pkg::REG_GAIN_I:     gain_i_q     <= pwdata[7:0];
				pdds_pkg::REG_GAIN_D:     gain_d_q     <= pwdata[7:0];
				pdds_pkg::REG_BASE_SPEED: base_speed_q <= pwdata[16:0];
				pdds_pkg::REG_MAX_SPEED:  max_speed_q  <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	// sequencer and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pdds_pkg::ST_IDLE;
			cnt_q        <= 6'd0;
			last_time_q  <= 32'd0;
			integral_q   <= 48'd0;
			last_error_q <= 16'd0;
		end else begin
			case (state_q)
				pdds_pkg::ST_IDLE: begin
					if (accept) begin
						last_time_q <= in_time;
						if (in_op == pdds_pkg::OP_RESET) begin
							integral_q   <= 48'd0;
							last_error_q <= 16'd0;
							state_q      <= pdds_pkg::ST_OUT;
						end else begin
							last_error_q <= in_err;
							cnt_q        <= pdds_pkg::STEPS_E_DT;
							state_q      <= pdds_pkg::ST_MUL_E;
						end
					end
				end
				pdds_pkg::ST_MUL_E: begin
					cnt_q <= cnt_q - 6'd1;
					if (step_last) begin
						state_q <= pdds_pkg::ST_INTEG;
					end
				end
				pdds_pkg::ST_INTEG: begin
					integral_q <= integ_sat;
					state_q    <= pdds_pkg::ST_LOAD_I;
				end
				pdds_pkg::ST_LOAD_I: begin
					cnt_q   <= pdds_pkg::STEPS_GAIN;
					state_q <= pdds_pkg::ST_MUL_I;
				end
				pdds_pkg::ST_MUL_I: begin
					if (step_last) begin
						cnt_q   <= pdds_pkg::STEPS_DIV_I;
						state_q <= pdds_pkg::ST_DIV_I;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				pdds_pkg::ST_DIV_I: begin
					cnt_q <= cnt_q - 6'd1;
					if (step_last) begin
						state_q <= pdds_pkg::ST_LOAD_N;
					end
				end
				pdds_pkg::ST_LOAD_N: begin
					// no derivative when no time has passed
					if (zero_q) begin
						state_q <= pdds_pkg::ST_LOAD_D;
					end else begin
						cnt_q   <= pdds_pkg::STEPS_US;
						state_q <= pdds_pkg::ST_MUL_N;
					end
				end
				pdds_pkg::ST_MUL_N: begin
					if (step_last) begin
						cnt_q   <= pdds_pkg::STEPS_DIV_D;
						state_q <= pdds_pkg::ST_DIV_D;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				pdds_pkg::ST_DIV_D: begin
					cnt_q <= cnt_q - 6'd1;
					if (step_last) begin
						state_q <= pdds_pkg::ST_LOAD_D;
					end
				end
				pdds_pkg::ST_LOAD_D: begin
					if (zero_q) begin
						state_q <= pdds_pkg::ST_SUM;
					end else begin
						cnt_q   <= pdds_pkg::STEPS_GAIN;
						state_q <= pdds_pkg::ST_MUL_D;
					end
				end
				pdds_pkg::ST_MUL_D: begin
					cnt_q <= cnt_q - 6'd1;
					if (step_last) begin
						state_q <= pdds_pkg::ST_SUM;
					end
				end
				pdds_pkg::ST_SUM: begin
					state_q <= pdds_pkg::ST_OUT;
				end
				pdds_pkg::ST_OUT: begin
					if (out_load) begin
						state_q <= pdds_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= pdds_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			pdds_pkg::ST_IDLE: begin
				if (accept) begin
					e_q          <= in_err;
					dt_q         <= dt_in;
					diff_q       <= diff_in;
					zero_q       <= (in_op == pdds_pkg::OP_SAMPLE) && (dt_in == 32'd0);
					u_q          <= 32'd0;
					mul_acc_q    <= 56'd0;
					mul_mcand_q  <= {32'd0, eabs_in};
					mul_mplier_q <= dt_in;
				end
			end
			pdds_pkg::ST_MUL_E, pdds_pkg::ST_MUL_D: begin
				mul_acc_q    <= mul_acc_d;
				mul_mplier_q <= {mul_mplier_q[30:0], 1'b0};
			end
			pdds_pkg::ST_LOAD_I: begin
				mul_acc_q    <= 56'd0;
				mul_mcand_q  <= integ_abs;
				mul_mplier_q <= {gain_i_q, 24'd0};
			end
			pdds_pkg::ST_MUL_I: begin
				mul_acc_q    <= mul_acc_d;
				mul_mplier_q <= {mul_mplier_q[30:0], 1'b0};
				if (step_last) begin
					div_num_q <= mul_acc_d;
					div_rem_q <= 32'd0;
					div_den_q <= {12'd0, pdds_pkg::US_PER_S};
				end
			end
			pdds_pkg::ST_DIV_I, pdds_pkg::ST_DIV_D: begin
				div_num_q <= div_num_d;
				div_rem_q <= div_rem_d;
			end
			pdds_pkg::ST_LOAD_N: begin
				iterm_q      <= iterm;
				mul_acc_q    <= 56'd0;
				mul_mcand_q  <= {32'd0, diff_abs[15:0]};
				mul_mplier_q <= {pdds_pkg::US_PER_S, 12'd0};
			end
			pdds_pkg::ST_MUL_N: begin
				mul_acc_q    <= mul_acc_d;
				mul_mplier_q <= {mul_mplier_q[30:0], 1'b0};
				if (step_last) begin
					// 36-bit numerator, left-aligned for 36 quotient steps
					div_num_q <= {mul_acc_d[35:0], 20'd0};
					div_rem_q <= 32'd0;
					div_den_q <= dt_q;
				end
			end
			pdds_pkg::ST_LOAD_D: begin
				ipterm_q     <= ipterm;
				mul_acc_q    <= 56'd0;
				mul_mcand_q  <= {12'd0, div_num_q[35:0]};
				mul_mplier_q <= {gain_d_q, 24'd0};
			end
			pdds_pkg::ST_SUM: begin
				u_q <= u_sat;
			end
			pdds_pkg::ST_OUT: begin
				if (out_load) begin
					left_q  <= clamp_speed(spd_base + spd_u, max_speed_q);
					right_q <= clamp_speed(spd_base - spd_u, max_speed_q);
					cv_q    <= u_q;
					zi_q    <= zero_q;
				end
			end
			default: ;
		endcase
	end

	// output word handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- sim/pid_differential_drive_step_tb.sv -----
// Testbench for pid_differential_drive_step: directed and random sample words
// checked field by field against an in-bench fixed-point PID predictor.
// Depends on pdds_pkg and the pid_differential_drive_step RTL.
`default_nettype none

module pid_differential_drive_step_tb;

	localparam longint INTEG_HI   = (longint'(1) <<< 47) - 1;
	localparam longint INTEG_LO   = -(longint'(1) <<< 47);
	localparam longint CTRL_HI    = (longint'(1) <<< 31) - 1;
	localparam longint CTRL_LO    = -(longint'(1) <<< 31);
	localparam longint US_PER_SEC = longint'(pdds_pkg::US_PER_S);

	localparam logic [7:0]  GAIN_TOP  = 8'hFF;
	localparam logic [16:0] SPEED_TOP = 17'h1FFFF;

	localparam int unsigned CYCLE_LIMIT     = 3000000;
	localparam int          DRAIN_CYCLES    = 200;
	localparam int          PHASES          = 8;
	localparam int          ITEMS_PER_PHASE = 110;

	typedef struct packed {
		logic [16:0] left;
		logic [16:0] right;
		logic [31:0] ctrl;
		logic        zero_iv;
	} wheel_cmd_t;

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [47:0]                   s_tdata  = '0;   // line_error[15:0], time_us[47:16]
	logic                          s_tuser  = 1'b0; // opcode
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [71:0]                   m_tdata;         // left[16:0], right[33:17], control[65:34]
	logic                          m_tuser;         // zero_interval
	logic                          psel     = 1'b0;
	logic                          penable  = 1'b0;
	logic                          pwrite   = 1'b0;
	logic [pdds_pkg::PADDR_W-1:0]  paddr    = '0;
	logic [31:0]                   pwdata   = '0;
	logic [31:0]                   prdata;
	logic                          pready;

	// predictor copy of the registers and the controller state
	logic [7:0]  kp       = pdds_pkg::GAIN_P_RST;
	logic [7:0]  ki       = pdds_pkg::GAIN_I_RST;
	logic [7:0]  kd       = pdds_pkg::GAIN_D_RST;
	logic [16:0] base_spd = pdds_pkg::BASE_SPEED_RST;
	logic [16:0] max_spd  = pdds_pkg::MAX_SPEED_RST;
	logic [31:0] prev_stamp = '0;
	longint      integ_acc  = 0;
	longint      prev_err   = 0;

	wheel_cmd_t  wheel_cmds_due[$];
	int          mismatches   = 0;
	int          results_seen = 0;
	int          tx_idle_pct  = 0;
	int          rx_stall_pct = 0;
	int          stall_left   = 0;
	int unsigned cycle_count  = 0;

	pid_differential_drive_step dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("pid_differential_drive_step_tb NOT OK");
			$finish;
		end
	end

	function automatic logic [16:0] clamp_speed(longint v);
		if (v < 0)
			return '0;
		if (v > longint'(max_spd))
			return max_spd;
		return v[16:0];
	endfunction

	function automatic wheel_cmd_t compute_wheel_cmd(logic op, logic signed [15:0] err,
			logic [31:0] stamp);
		wheel_cmd_t  r;
		logic [31:0] dt;
		longint      e, span, integ, deriv, u;
		e = longint'(err);
		u = 0;
		r.zero_iv = 1'b0;
		if (op == pdds_pkg::OP_RESET) begin
			integ_acc = 0;
			prev_err = 0;
		end else begin
			dt = stamp - prev_stamp;
			span = longint'({32'd0, dt});
			integ = integ_acc + e * span;
			if (integ > INTEG_HI)
				integ = INTEG_HI;
			else if (integ < INTEG_LO)
				integ = INTEG_LO;
			deriv = 0;
			if (dt == '0)
				r.zero_iv = 1'b1;
			else
				deriv = (e - prev_err) * US_PER_SEC / span;
			u = longint'(kp) * e + longint'(kd) * deriv + longint'(ki) * integ / US_PER_SEC;
			if (u > CTRL_HI)
				u = CTRL_HI;
			else if (u < CTRL_LO)
				u = CTRL_LO;
			integ_acc = integ;
			prev_err = e;
		end
		prev_stamp = stamp;
		r.left = clamp_speed(longint'(base_spd) + u);
		r.right = clamp_speed(longint'(base_spd) - u);
		r.ctrl = u[31:0];
		return r;
	endfunction

	function automatic logic [7:0] pick_gain();
		case ($urandom_range(3))
			0: return '0;
			1: return GAIN_TOP;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [16:0] pick_speed();
		case ($urandom_range(3))
			0: return '0;
			1: return SPEED_TOP;
			default: return 17'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		$display("MISMATCH %s: got %0h, want %0h (result word %0d)",
			what, got, want, results_seen);
	endtask

	always @(posedge clk) begin : check_results
		wheel_cmd_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (wheel_cmds_due.size() == 0) begin
				report_mismatch("unexpected word", m_tdata[63:0], '0);
			end else begin
				want = wheel_cmds_due.pop_front();
				if (m_tdata[16:0] !== want.left)
					report_mismatch("left_speed", m_tdata[16:0], want.left);
				if (m_tdata[33:17] !== want.right)
					report_mismatch("right_speed", m_tdata[33:17], want.right);
				if (m_tdata[65:34] !== want.ctrl)
					report_mismatch("control_value", m_tdata[65:34], want.ctrl);
				if (m_tuser !== want.zero_iv)
					report_mismatch("zero_interval", m_tuser, want.zero_iv);
			end
			results_seen++;
		end
	end

	// receiver: short random stalls plus an occasional long one
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (rx_stall_pct != 0 && $urandom_range(1023) == 0) begin
			stall_left <= $urandom_range(300, 1);
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			pdds_pkg::REG_GAIN_P:     kp = data[7:0];
			pdds_pkg::REG_GAIN_I:     ki = data[7:0];
			pdds_pkg::REG_GAIN_D:     kd = data[7:0];
			pdds_pkg::REG_BASE_SPEED: base_spd = data[16:0];
			pdds_pkg::REG_MAX_SPEED:  max_spd = data[16:0];
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read(input logic [2:0] idx, output logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_registers();
		logic [31:0] rd, want;
		for (int k = pdds_pkg::REG_GAIN_P; k <= pdds_pkg::REG_MAX_SPEED; k++) begin
			apb_read(k[2:0], rd);
			case (k[2:0])
				pdds_pkg::REG_GAIN_P:     want = {24'd0, kp};
				pdds_pkg::REG_GAIN_I:     want = {24'd0, ki};
				pdds_pkg::REG_GAIN_D:     want = {24'd0, kd};
				pdds_pkg::REG_BASE_SPEED: want = {15'd0, base_spd};
				default:                  want = {15'd0, max_spd};
			endcase
			if (rd !== want)
				report_mismatch("register readback", rd, want);
		end
	endtask

	// upper data bits carry junk; unmapped slots get a write that must not land
	task automatic load_settings(input logic [7:0] p, i, d, input logic [16:0] base, top);
		logic [31:0] junk;
		junk = $urandom;
		apb_write(pdds_pkg::REG_GAIN_P, {junk[31:8], p});
		apb_write(pdds_pkg::REG_GAIN_I, {junk[31:8], i});
		apb_write(pdds_pkg::REG_GAIN_D, {junk[31:8], d});
		apb_write(pdds_pkg::REG_BASE_SPEED, {junk[31:17], base});
		apb_write(pdds_pkg::REG_MAX_SPEED, {junk[31:17], top});
		for (int k = pdds_pkg::REG_MAX_SPEED + 1; k < 2 ** (pdds_pkg::PADDR_W - 2); k++)
			apb_write(k[2:0], $urandom);
		check_registers();
	endtask

	task automatic send_sample(input logic op, input logic signed [15:0] err,
			input logic [31:0] stamp);
		int gap;
		gap = 0;
		if (tx_idle_pct != 0) begin
			if ($urandom_range(15) == 0)
				gap = $urandom_range(200, 1);
			else
				while ($urandom_range(99) < tx_idle_pct) gap++;
		end
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {stamp, err};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		wheel_cmds_due.push_back(compute_wheel_cmd(op, err, stamp));
	endtask

	task automatic drain_wheel_cmds();
		s_tvalid <= 1'b0;
		while (wheel_cmds_due.size() != 0 || !s_tready) @(posedge clk);
	endtask

	task automatic test_register_defaults();
		check_registers();
	endtask

	task automatic test_zero_interval_and_wrap();
		send_sample(pdds_pkg::OP_SAMPLE, 16'sd0, 32'd0);          // no time since reset
		send_sample(pdds_pkg::OP_SAMPLE, 16'sd256, 32'd1000);
		send_sample(pdds_pkg::OP_SAMPLE, -16'sd256, 32'd1000);    // repeated stamp
		send_sample(pdds_pkg::OP_SAMPLE, 16'sh7FFF, 32'd2000);
		send_sample(pdds_pkg::OP_SAMPLE, 16'sh8000, 32'd2001);    // full swing in 1 us
		send_sample(pdds_pkg::OP_RESET, 16'sh7FFF, 32'hFFFF_FF00);
		send_sample(pdds_pkg::OP_SAMPLE, 16'sd100, 32'h0000_0010); // timestamp wraps
	endtask

	task automatic test_integral_saturation();
		// each step spans 2^32-1 us, so two full-scale errors hit the rail
		send_sample(pdds_pkg::OP_SAMPLE, 16'sh7FFF, 32'h0000_000F);
		send_sample(pdds_pkg::OP_SAMPLE, 16'sh7FFF, 32'h0000_000E);
		send_sample(pdds_pkg::OP_SAMPLE, 16'sh8000, 32'h0000_000D);
		send_sample(pdds_pkg::OP_SAMPLE, 16'sh8000, 32'h0000_000C);
		send_sample(pdds_pkg::OP_SAMPLE, 16'sh8000, 32'h0000_000B);
		send_sample(pdds_pkg::OP_RESET, 16'sh5555, 32'hFFFF_FFFF);
		send_sample(pdds_pkg::OP_SAMPLE, 16'sh2AAA, 32'hFFFF_FFFF);
		send_sample(pdds_pkg::OP_SAMPLE, -16'sd1, 32'h8000_0000);
	endtask

	task automatic test_speed_clamps();
		drain_wheel_cmds();
		load_settings('0, '0, '0, '0, '0);
		send_sample(pdds_pkg::OP_SAMPLE, 16'sd1000, 32'h8000_0064);
		send_sample(pdds_pkg::OP_RESET, 16'sd0, 32'h8000_0100);
		drain_wheel_cmds();
		load_settings(GAIN_TOP, GAIN_TOP, GAIN_TOP, SPEED_TOP, SPEED_TOP);
		send_sample(pdds_pkg::OP_SAMPLE, 16'sh7FFF, 32'h8000_0105);
		send_sample(pdds_pkg::OP_SAMPLE, 16'sh8000, 32'h8000_0106);
		drain_wheel_cmds();
		load_settings(8'd1, '0, '0, 17'd100000, 17'd50000); // base above the clamp
		send_sample(pdds_pkg::OP_RESET, 16'sd0, 32'h8000_0200);
		send_sample(pdds_pkg::OP_SAMPLE, 16'sd0, 32'h8000_0300);
	endtask

	task automatic test_random_traffic();
		logic signed [15:0] err;
		logic [31:0]        stamp;
		logic               op;
		int                 pick;
		err = '0;
		stamp = $urandom;
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_wheel_cmds();
			case (ph % 4)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct = 68;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 68;
				end
				default: begin
					tx_idle_pct = 34;
					rx_stall_pct = 34;
				end
			endcase
			if (ph == 2)
				load_settings(GAIN_TOP, GAIN_TOP, GAIN_TOP, SPEED_TOP, SPEED_TOP);
			else if (ph == 5)
				load_settings('0, '0, '0, pick_speed(), pick_speed());
			else
				load_settings(pick_gain(), pick_gain(), pick_gain(), pick_speed(), pick_speed());
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// hold off until the block has emptied once per phase
				if (n == ITEMS_PER_PHASE / 2)
					drain_wheel_cmds();
				pick = $urandom_range(99);
				if (pick < 52)
					stamp += $urandom_range(20000, 200);
				else if (pick < 64)
					stamp += $urandom_range(8, 1);
				else if (pick < 78)
					stamp += $urandom;
				else if (pick < 90)
					stamp = $urandom;
				// otherwise the stamp repeats: zero interval
				pick = $urandom_range(99);
				if (pick < 40)
					err = 16'(int'($urandom_range(4000)) - 2000);
				else if (pick < 65)
					err = 16'($urandom);
				else if (pick < 75)
					case ($urandom_range(2))
						0: err = 16'sh7FFF;
						1: err = 16'sh8000;
						default: err = '0;
					endcase
				else
					err = 16'(int'(err) + int'($urandom_range(200)) - 100);
				op = ($urandom_range(23) == 0) ? pdds_pkg::OP_RESET : pdds_pkg::OP_SAMPLE;
				send_sample(op, err, stamp);
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_register_defaults();
		test_zero_interval_and_wrap();
		test_integral_saturation();
		test_speed_clamps();
		test_random_traffic();
		drain_wheel_cmds();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("pid_differential_drive_step_tb OK");
		else
			$display("pid_differential_drive_step_tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

// ----- pid_differential_drive_step.f -----
design/pdds_pkg.sv
design/pid_differential_drive_step.sv
sim/pid_differential_drive_step_tb.sv
